FILE: design/nsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsr_pkg: shared constants and types for the Newton square root core
// Field widths, fixed-point start value, step cap and control state codes.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // field widths
  localparam int VAL_W   = 40;             // Q24.16 value and tolerance
  localparam int ROOT_W  = 56;             // Q32.24 guess
  localparam int STEPS_W = 7;              // reported step count
  localparam int SQ_W    = 2 * ROOT_W;     // full-width square / error magnitude
  localparam int FRAC_SH = 32;             // Q.16 -> Q.48 alignment
  localparam int REM_W   = ROOT_W + 2;     // divider partial remainder (shifted)
  localparam int CNT_W   = $clog2(SQ_W + 1);

  // iteration cap (1..255) and its counter
  localparam int MAX_STEPS = 64;
  localparam int STEP_CNT_W = 8;

  // 0.1 in Q32.24, rounded to nearest
  localparam logic [ROOT_W-1:0] GUESS_INIT = ROOT_W'(1677722);

  // control states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQR  = 7'b0000010,
    ST_ERR  = 7'b0000100,
    ST_CHK  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

endpackage

FILE: design/newton_square_root_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_square_root_core: fixed-point Newton-Raphson square root
// Bit-serial square and restoring divide around a small control sequencer.
// ----------------------------------------------------------------------------
// One value (unsigned Q24.16) is taken at a time and its root comes back as an
// unsigned Q32.24 guess with the number of Newton steps and a not_converged
// flag. Each round squares the guess with a shift-add multiplier, then forms
// and tests the error; when a step is needed, a bit-serial restoring divider
// produces the 112-bit correction and the update state applies it. The next
// value is accepted once the current one has been posted to the output
// register, which holds it until taken. The tolerance register (reset 66)
// should be written only while the core is idle.
module newton_square_root_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nsr_pkg::VAL_W-1:0]      in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nsr_pkg::ROOT_W-1:0]     out_root,
  output logic [nsr_pkg::STEPS_W-1:0]    out_steps,
  output logic                           out_not_converged,
  input  logic                           cfg_we,
  input  logic [nsr_pkg::VAL_W-1:0]      cfg_tolerance
);

  localparam int ROOT_W = nsr_pkg::ROOT_W;
  localparam int SQ_W   = nsr_pkg::SQ_W;
  localparam int REM_W  = nsr_pkg::REM_W;
  localparam int CNT_W  = nsr_pkg::CNT_W;
  localparam int SCW    = nsr_pkg::STEP_CNT_W;

  nsr_pkg::state_t state_r, state_nxt;

  logic [nsr_pkg::VAL_W-1:0] tol_r, val_r, val_nxt;
  logic [ROOT_W-1:0]         g_r, g_nxt, m_r, m_nxt;
  logic [SQ_W-1:0]           acc_r, acc_nxt, n_r, n_nxt;
  logic [REM_W-2:0]          rem_r, rem_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [SCW-1:0]            steps_r, steps_nxt;
  logic                      neg_r, neg_nxt, flag_r, flag_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]         out_root_r, out_root_nxt;
  logic [nsr_pkg::STEPS_W-1:0] out_steps_r, out_steps_nxt;
  logic                      out_nc_r, out_nc_nxt;

  // datapath helpers
  logic [ROOT_W:0]   sq_sum;
  logic [SQ_W-1:0]   target, tol_w;
  logic              sq_lt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W:0]    trial;
  logic [ROOT_W:0]   g_add;
  logic              q_hi_nz;

  assign target  = SQ_W'({val_r, nsr_pkg::FRAC_SH'(0)});
  assign tol_w   = SQ_W'({tol_r, nsr_pkg::FRAC_SH'(0)});
  assign sq_sum  = {1'b0, acc_r[SQ_W-1:ROOT_W]} + (m_r[0] ? {1'b0, g_r} : '0);
  assign sq_lt   = acc_r < target;
  assign rem_sh  = {rem_r, n_r[SQ_W-1]};
  assign trial   = {1'b0, rem_sh} - {2'b00, g_r, 1'b0};
  assign g_add   = {1'b0, g_r} + {1'b0, n_r[ROOT_W-1:0]};
  assign q_hi_nz = |n_r[SQ_W-1:ROOT_W];

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= nsr_pkg::VAL_W'(66);
    end else if (cfg_we) begin
      tol_r <= cfg_tolerance;
    end
  end

  // sequencer and serial datapath
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    g_nxt         = g_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    neg_nxt       = neg_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_root_nxt  = out_root_r;
    out_steps_nxt = out_steps_r;
    out_nc_nxt    = out_nc_r;
    unique case (state_r)
      nsr_pkg::ST_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_value;
          g_nxt     = nsr_pkg::GUESS_INIT;
          m_nxt     = nsr_pkg::GUESS_INIT;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          steps_nxt = '0;
          flag_nxt  = 1'b0;
          state_nxt = nsr_pkg::ST_SQR;
        end
      end
      nsr_pkg::ST_SQR: begin
        // shift-add square, one multiplier bit per cycle
        acc_nxt = {sq_sum, acc_r[ROOT_W-1:1]};
        m_nxt   = m_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          state_nxt = nsr_pkg::ST_ERR;
        end
      end
      nsr_pkg::ST_ERR: begin
        neg_nxt   = sq_lt;
        n_nxt     = sq_lt ? (target - acc_r) : (acc_r - target);
        state_nxt = nsr_pkg::ST_CHK;
      end
      nsr_pkg::ST_CHK: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        if (tol_w >= n_r) begin
          state_nxt = nsr_pkg::ST_FIN;
        end else if (steps_r >= SCW'(nsr_pkg::MAX_STEPS)) begin
          flag_nxt  = 1'b1;
          state_nxt = nsr_pkg::ST_FIN;
        end else begin
          state_nxt = nsr_pkg::ST_DIV;
        end
      end
      nsr_pkg::ST_DIV: begin
        // restoring divide by 2*guess; quotient bits shift into n_r
        cnt_nxt = cnt_r + CNT_W'(1);
        if (!trial[REM_W]) begin
          rem_nxt = trial[REM_W-2:0];
          n_nxt   = {n_r[SQ_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[REM_W-2:0];
          n_nxt   = {n_r[SQ_W-2:0], 1'b0};
        end
        if (cnt_r == CNT_W'(SQ_W - 1)) begin
          state_nxt = nsr_pkg::ST_UPD;
        end
      end
      nsr_pkg::ST_UPD: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (neg_r && (q_hi_nz || g_add[ROOT_W])) begin
          flag_nxt  = 1'b1;
          state_nxt = nsr_pkg::ST_FIN;
        end else if (!neg_r && (q_hi_nz || n_r[ROOT_W-1:0] >= g_r)) begin
          flag_nxt  = 1'b1;
          state_nxt = nsr_pkg::ST_FIN;
        end else begin
          g_nxt     = neg_r ? g_add[ROOT_W-1:0] : (g_r - n_r[ROOT_W-1:0]);
          m_nxt     = g_nxt;
          steps_nxt = steps_r + SCW'(1);
          state_nxt = nsr_pkg::ST_SQR;
        end
      end
      nsr_pkg::ST_FIN: begin
        // post once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = g_r;
          out_steps_nxt = steps_r[nsr_pkg::STEPS_W-1:0];
          out_nc_nxt    = flag_r;
          state_nxt     = nsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nsr_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    g_r         <= g_nxt;
    m_r         <= m_nxt;
    acc_r       <= acc_nxt;
    n_r         <= n_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    steps_r     <= steps_nxt;
    neg_r       <= neg_nxt;
    flag_r      <= flag_nxt;
    out_root_r  <= out_root_nxt;
    out_steps_r <= out_steps_nxt;
    out_nc_r    <= out_nc_nxt;
  end

  assign in_ready          = (state_r == nsr_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_root          = out_root_r;
  assign out_steps         = out_steps_r;
  assign out_not_converged = out_nc_r;

endmodule

FILE: test/newton_square_root_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_square_root_core_test: self-checking bench for the Newton root core
// Drives values through the valid/ready input under several tolerance
// settings and compares each root, step count and flag with a local model.
// ----------------------------------------------------------------------------
module newton_square_root_core_test;

  typedef struct {
    logic [nsr_pkg::ROOT_W-1:0]  root;
    logic [nsr_pkg::STEPS_W-1:0] steps;
    logic                        not_converged;
  } root_result_t;

  // Tracks expected roots and compares them with what the core returns
  class root_tracker;
    root_result_t              pending_roots[$];
    logic [nsr_pkg::VAL_W-1:0] tolerance = nsr_pkg::VAL_W'(66);
    int unsigned               mismatches = 0;
    int unsigned               values_taken = 0;

    // Newton iteration at full width, same stop rules as the core
    function root_result_t solve_root(logic [nsr_pkg::VAL_W-1:0] value);
      logic [127:0] target, tol, guess, sq, mag, quot, mask56;
      logic         below;
      int           n;
      root_result_t r;
      mask56 = (128'(1) << nsr_pkg::ROOT_W) - 1;
      target = 128'(value) << nsr_pkg::FRAC_SH;
      tol    = 128'(tolerance) << nsr_pkg::FRAC_SH;
      guess  = 128'(nsr_pkg::GUESS_INIT);
      n      = 0;
      r.not_converged = 1'b0;
      forever begin
        sq    = guess * guess;
        below = sq < target;
        mag   = below ? target - sq : sq - target;
        if (mag <= tol) break;
        if (n >= nsr_pkg::MAX_STEPS) begin
          r.not_converged = 1'b1;
          break;
        end
        quot = mag / (guess << 1);
        if (below) begin
          // growing past 56 bits is refused
          if (quot > mask56 - guess) begin
            r.not_converged = 1'b1;
            break;
          end
          guess = guess + quot;
        end else begin
          // shrinking to zero or below is refused
          if (quot >= guess) begin
            r.not_converged = 1'b1;
            break;
          end
          guess = guess - quot;
        end
        n++;
      end
      r.root  = guess[nsr_pkg::ROOT_W-1:0];
      r.steps = nsr_pkg::STEPS_W'(n);
      return r;
    endfunction

    function void note_value(logic [nsr_pkg::VAL_W-1:0] value);
      pending_roots.push_back(solve_root(value));
      values_taken++;
    endfunction

    function void check_root(logic [nsr_pkg::ROOT_W-1:0] root,
                             logic [nsr_pkg::STEPS_W-1:0] steps, logic nc);
      root_result_t e;
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: root=%h steps=%0d nc=%b", root, steps, nc);
        return;
      end
      e = pending_roots.pop_front();
      if (root !== e.root || steps !== e.steps || nc !== e.not_converged) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected root=%h steps=%0d nc=%b,",
                    " got root=%h steps=%0d nc=%b"},
                   e.root, e.steps, e.not_converged, root, steps, nc);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [nsr_pkg::VAL_W-1:0]   in_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [nsr_pkg::ROOT_W-1:0]  out_root;
  logic [nsr_pkg::STEPS_W-1:0] out_steps;
  logic                        out_not_converged;
  logic                        cfg_we;
  logic [nsr_pkg::VAL_W-1:0]   cfg_tolerance;

  root_tracker tracker = new();
  bit          idle_on = 1'b0;
  bit          hold_done = 1'b0;

  newton_square_root_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_root          (out_root),
    .out_steps         (out_steps),
    .out_not_converged (out_not_converged),
    .cfg_we            (cfg_we),
    .cfg_tolerance     (cfg_tolerance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(30, 400);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Result side: random stalls plus one long hold-off to back up the core
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        tracker.check_root(out_root, out_steps, out_not_converged);
      if (!hold_done && tracker.values_taken >= 40) begin
        hold_done = 1'b1;
        stall_left = 3000;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= 200000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one value; valid stays high across back-to-back transactions
  task automatic send_value(logic [nsr_pkg::VAL_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    tracker.note_value(value);
  endtask

  // Drain, let the core settle, then write the tolerance
  task automatic set_tolerance(logic [nsr_pkg::VAL_W-1:0] tol);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_tolerance <= tol;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.tolerance = tol;
  endtask

  function automatic logic [nsr_pkg::VAL_W-1:0] random_value();
    logic [nsr_pkg::VAL_W-1:0] v;
    int unsigned               k;
    v = nsr_pkg::VAL_W'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: return v;
      1: return v >> $urandom_range(0, nsr_pkg::VAL_W - 1);
      2: begin
        k = $urandom_range(0, 4095);
        return nsr_pkg::VAL_W'(k * k) << 16;
      end
      default: return nsr_pkg::VAL_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [nsr_pkg::VAL_W-1:0] tols[7];
    int unsigned               counts[7];
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_value      <= '0;
    cfg_we        <= 1'b0;
    cfg_tolerance <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and bit patterns at reset tolerance
    send_value('0);
    send_value(nsr_pkg::VAL_W'(1));
    send_value({nsr_pkg::VAL_W{1'b1}});
    send_value(nsr_pkg::VAL_W'(1) << 39);
    send_value(nsr_pkg::VAL_W'(1) << 16);
    send_value(nsr_pkg::VAL_W'(4) << 16);
    send_value(40'h5555555555);
    send_value(40'hAAAAAAAAAA);
    send_value(40'h00FFFFFFFF);
    // zero tolerance: exact stop or step cap
    set_tolerance('0);
    send_value('0);
    send_value(nsr_pkg::VAL_W'(1) << 16);
    send_value({nsr_pkg::VAL_W{1'b1}});
    send_value(nsr_pkg::VAL_W'(3));
    // widest tolerance: no step at all
    set_tolerance({nsr_pkg::VAL_W{1'b1}});
    send_value('0);
    send_value({nsr_pkg::VAL_W{1'b1}});
    send_value(40'h5555555555);

    // random phases over several tolerances, idling on and off
    tols   = '{nsr_pkg::VAL_W'(66), nsr_pkg::VAL_W'(1), nsr_pkg::VAL_W'(1000),
               nsr_pkg::VAL_W'(65536), nsr_pkg::VAL_W'({$urandom, $urandom}),
               {nsr_pkg::VAL_W{1'b1}}, '0};
    counts = '{300, 260, 260, 260, 260, 200, 40};
    for (int p = 0; p < 7; p++) begin
      set_tolerance(tols[p]);
      idle_on = (p % 3) != 1;
      for (int i = 0; i < counts[p]; i++) send_value(random_value());
    end

    in_valid <= 1'b0;
    while (tracker.pending_roots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
design/nsr_pkg.sv
design/newton_square_root_core.sv
test/newton_square_root_core_test.sv
